/* sv/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg: shared types and codes of the random sample set
// Operation codes, status codes and the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

	// function codes on the request channel
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_GET    = 2'd2;

	// status codes on the response channel
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_GET,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] item_value;
		logic [31:0]        random_draw;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [1:0]         status;
		logic signed [31:0] member_out;
		logic [4:0]         member_count;
	} rsp_t;

endpackage

`default_nettype wire

/* sv/rss_req_if.sv */
// ----------------------------------------------------------------------------
// rss_req_if: request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] item_value;
	logic [31:0]        random_draw;

	modport source (output valid, output func, output item_value, output random_draw,
		input ready);
	modport sink (input valid, input func, input item_value, input random_draw,
		output ready);
endinterface

`default_nettype wire

/* sv/rss_rsp_if.sv */
// ----------------------------------------------------------------------------
// rss_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_rsp_if;
	logic               valid;
	logic               ready;
	logic               success;
	logic [1:0]         status;
	logic signed [31:0] member_out;
	logic [4:0]         member_count;

	modport source (output valid, output success, output status, output member_out,
		output member_count, input ready);
	modport sink (input valid, input success, input status, input member_out,
		input member_count, output ready);
endinterface

`default_nettype wire

/* sv/random_sample_set.sv */
// ----------------------------------------------------------------------------
// random_sample_set: set of distinct 32-bit values with random sampling
// Insert, remove and get-random on a dense member array held in RAM.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH distinct signed 32-bit members packed at the
// bottom of a single RAM. Each request word gives one response word, in order.
// Insert and remove search the members one RAM entry per clock, and a remove
// that does not hit the last member then reads the last member and copies it
// into the freed slot. Get-random works out random_draw modulo the count one
// bit per cycle, then reads the RAM. An empty get-random or an unused function
// code goes straight to the result. A two-word queue in front of the engine
// takes new requests while the engine is busy, and a result register lets
// the engine start the next word while the previous response waits to be
// taken. No clearing pass is needed after reset: entries at or above the
// count are never read.
`default_nettype none

module random_sample_set import rss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rss_req_if.sink   req,
	rss_rsp_if.source rsp
);

	// decoded request between intake and engine
	logic req_valid;
	req_t req_head;
	logic req_pop;

	// response word from the engine's output register
	logic rsp_valid;
	rsp_t rsp_word;

	rss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_head (req_head),
		.req_pop  (req_pop)
	);

	rss_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_head (req_head),
		.req_pop  (req_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp.ready),
		.rsp_word (rsp_word)
	);

	// drive the response channel
	assign rsp.valid        = rsp_valid;
	assign rsp.success      = rsp_word.success;
	assign rsp.status       = rsp_word.status;
	assign rsp.member_out   = rsp_word.member_out;
	assign rsp.member_count = rsp_word.member_count;

endmodule

`default_nettype wire

/* sv/rss_ram.sv */
// ----------------------------------------------------------------------------
// rss_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/rss_front.sv */
// ----------------------------------------------------------------------------
// rss_front: request intake
// Accepts request words, decodes the function code and holds up to two
// decoded requests for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front import rss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	rss_req_if.sink req,
	output logic   req_valid,
	output req_t   req_head,
	input  logic   req_pop
);

	req_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       push;
	logic       pop;
	req_t       dec;

	// decode the function code, unused code becomes a no-op
	always_comb begin
		dec.item_value  = req.item_value;
		dec.random_draw = req.random_draw;
		unique case (req.func)
			FUNC_INSERT: dec.op = OP_INSERT;
			FUNC_REMOVE: dec.op = OP_REMOVE;
			FUNC_GET:    dec.op = OP_GET;
			default:     dec.op = OP_NOP;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign pop       = req_pop && (cnt_q != 2'd0);
	assign req_valid = (cnt_q != 2'd0);
	assign req_head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/rss_back.sv */
// ----------------------------------------------------------------------------
// rss_back: operation engine
// Scans the member RAM, appends, moves the last entry on remove, works out
// the draw remainder bit by bit, and holds the result word for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back import rss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req_head,
	output logic req_pop,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_RDLAST  = 3'd2;
	localparam logic [2:0] S_MOVE    = 3'd3;
	localparam logic [2:0] S_DIV     = 3'd4;
	localparam logic [2:0] S_GETRD   = 3'd5;
	localparam logic [2:0] S_GETWAIT = 3'd6;
	localparam logic [2:0] S_RESULT  = 3'd7;

	logic [2:0]    state_q;
	op_t           op_q;
	logic [31:0]   val_q;
	logic [31:0]   draw_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] iss_q;
	logic          chk_q;
	logic [AW-1:0] chk_idx_q;
	logic [AW-1:0] hit_idx_q;
	logic [CW-1:0] rem_q;
	logic [4:0]    bit_q;
	rsp_t          res_q;
	rsp_t          out_q;
	logic          out_valid_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_p1;
	logic          issue;
	logic          scan_hit;
	logic          scan_end;
	logic          is_full;
	logic [CW:0]   trial;
	logic [CW:0]   trial_sub;
	logic          trial_ge;
	logic          out_load;

	function automatic rsp_t mk_rsp(input logic s, input logic [1:0] st,
		input logic [31:0] m, input logic [CW-1:0] c);
		logic [CW+4:0] ext;
		rsp_t          r;
		ext            = {5'd0, c};
		r.success      = s;
		r.status       = st;
		r.member_out   = m;
		r.member_count = ext[4:0];
		return r;
	endfunction

	rss_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cnt_m1    = count_q - 1'b1;
	assign cnt_p1    = count_q + 1'b1;
	assign issue     = (iss_q < count_q);
	assign scan_hit  = chk_q && (rdata == val_q);
	assign scan_end  = !chk_q && !issue;
	assign is_full   = (count_q == FULL_CNT);
	assign trial     = {rem_q, draw_q[31]};
	assign trial_sub = trial - {1'b0, count_q};
	assign trial_ge  = (trial >= {1'b0, count_q});
	assign out_load  = (state_q == S_RESULT) && (!out_valid_q || rsp_ready);

	assign req_pop   = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = val_q;
		raddr = iss_q[AW-1:0];
		unique case (state_q)
			S_SCAN: begin
				we = scan_end && !scan_hit && (op_q == OP_INSERT) && !is_full;
			end
			S_RDLAST: begin
				raddr = cnt_m1[AW-1:0];
			end
			S_MOVE: begin
				we    = 1'b1;
				waddr = hit_idx_q;
				wdata = rdata;
			end
			S_GETRD: begin
				raddr = rem_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NOP;
			val_q       <= '0;
			draw_q      <= '0;
			count_q     <= '0;
			iss_q       <= '0;
			chk_q       <= 1'b0;
			chk_idx_q   <= '0;
			hit_idx_q   <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q   <= req_head.op;
						val_q  <= req_head.item_value;
						draw_q <= req_head.random_draw;
						iss_q  <= '0;
						chk_q  <= 1'b0;
						rem_q  <= '0;
						bit_q  <= '0;
						unique case (req_head.op)
							OP_INSERT, OP_REMOVE: begin
								state_q <= S_SCAN;
							end
							OP_GET: begin
								if (count_q == '0) begin
									res_q   <= mk_rsp(1'b0, ST_EMPTY, '0, count_q);
									state_q <= S_RESULT;
								end else begin
									state_q <= S_DIV;
								end
							end
							default: begin
								res_q   <= mk_rsp(1'b0, ST_DONE, '0, count_q);
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_SCAN: begin
					chk_q     <= issue;
					chk_idx_q <= iss_q[AW-1:0];
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (scan_hit) begin
						if (op_q == OP_INSERT) begin
							res_q   <= mk_rsp(1'b0, ST_MISS, '0, count_q);
							state_q <= S_RESULT;
						end else if (chk_idx_q == cnt_m1[AW-1:0]) begin
							// last entry removed, nothing to move
							count_q <= cnt_m1;
							res_q   <= mk_rsp(1'b1, ST_DONE, '0, cnt_m1);
							state_q <= S_RESULT;
						end else begin
							hit_idx_q <= chk_idx_q;
							state_q   <= S_RDLAST;
						end
					end else if (scan_end) begin
						if (op_q != OP_INSERT) begin
							res_q <= mk_rsp(1'b0, ST_MISS, '0, count_q);
						end else if (is_full) begin
							res_q <= mk_rsp(1'b0, ST_FULL, '0, count_q);
						end else begin
							count_q <= cnt_p1;
							res_q   <= mk_rsp(1'b1, ST_DONE, '0, cnt_p1);
						end
						state_q <= S_RESULT;
					end
				end
				S_RDLAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= cnt_m1;
					res_q   <= mk_rsp(1'b1, ST_DONE, '0, cnt_m1);
					state_q <= S_RESULT;
				end
				S_DIV: begin
					// restoring remainder, one draw bit a cycle
					rem_q  <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
					draw_q <= {draw_q[30:0], 1'b0};
					bit_q  <= bit_q + 5'd1;
					if (bit_q == 5'd31) begin
						state_q <= S_GETRD;
					end
				end
				S_GETRD: begin
					state_q <= S_GETWAIT;
				end
				S_GETWAIT: begin
					res_q   <= mk_rsp(1'b1, ST_DONE, rdata, count_q);
					state_q <= S_RESULT;
				end
				default: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/rss_checker.sv */
// ----------------------------------------------------------------------------
// rss_checker: port-level checks of the random sample set
// Consistency of response fields and stability of a stalled response.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker import rss_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_success,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_member_out,
	input logic [4:0]  rsp_member_count
);

	localparam int FULL_MOD = DEPTH % 32;
	localparam logic [4:0] FULL_CNT = FULL_MOD[4:0];

	// success only ever reports done
	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_success |-> rsp_status == ST_DONE)
		else $error("success with a non-done status");

	// a member is only returned on success
	a_member_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_success |-> rsp_member_out == 32'd0)
		else $error("member returned on a failed operation");

	// empty status only when no members are held
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> rsp_member_count == 5'd0)
		else $error("empty status with members held");

	// full status only at full occupancy
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_member_count == FULL_CNT)
		else $error("full status below full occupancy");

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
		&& $stable({rsp_success, rsp_status, rsp_member_out, rsp_member_count}))
		else $error("stalled response word changed");

endmodule

bind random_sample_set rss_checker #(
	.DEPTH(DEPTH)
) u_rss_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_success     (rsp.success),
	.rsp_status      (rsp.status),
	.rsp_member_out  (rsp.member_out),
	.rsp_member_count(rsp.member_count)
);

`default_nettype wire
